// ----- rtl/scp_pkg.sv -----
package scp_pkg;

	localparam int COORD_W = 32;
	localparam int NORM_W  = 18;
	localparam int OFFS_W  = 32;
	localparam int BAND_W  = 16;
	localparam int PROD_W  = NORM_W + COORD_W;
	// three products plus the shifted offset stay below 2^50 in magnitude
	localparam int DIST_W  = PROD_W + 2;
	localparam int DN_W    = DIST_W + 1;
	localparam int T_W     = 30;
	localparam int DELTA_W = COORD_W + 1;
	localparam int MUL_W   = DELTA_W + T_W;
	localparam int FRAC_W  = 16;

	localparam logic [2:0] REG_NORMAL_X = 3'd0;
	localparam logic [2:0] REG_NORMAL_Y = 3'd1;
	localparam logic [2:0] REG_NORMAL_Z = 3'd2;
	localparam logic [2:0] REG_OFFSET   = 3'd3;
	localparam logic [2:0] REG_BAND     = 3'd4;
	localparam logic [2:0] REG_KEEPBACK = 3'd5;

	localparam logic [1:0] SIDE_FRONT    = 2'd0;
	localparam logic [1:0] SIDE_BACK     = 2'd1;
	localparam logic [1:0] SIDE_COPLANAR = 2'd2;

	localparam logic [BAND_W-1:0] BAND_RESET = 16'd66;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t [2:0] point_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic signed [OFFS_W-1:0] offset;
		logic [BAND_W-1:0]        band;
		logic                     keep_back;
	} cfg_t;

	typedef struct packed {
		logic [1:0] sa;
		logic [1:0] sb;
		logic       kept;
		logic       cut;
		logic       repl_start;
		point_t     a;
		point_t     b;
	} info_t;

endpackage

// ----- rtl/segment_plane_clipper.sv -----
// Segment clipper against one plane, signed Q16.16 throughout.
// Input channel: in_valid/in_ready carries one segment per beat (start_x/y/z,
// end_x/y/z). Output channel: out_valid/out_ready carries one result beat per
// segment: kept flag, side class of each endpoint, and the clipped points.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data writes the
// plane normal (0..2), offset (3), coplanar band (4) and keep_back (5); other
// indexes are dropped. cfg_ready is always high. Write only while idle.
// The path runs through the distance and classification stages, a radix-2
// restoring divider that forms the cut scale one quotient bit per stage, and
// the interpolation stages.
// Throughput is one segment per cycle; every stage holds a valid bit.
// When the receiver stalls, the output register holds its beat and each
// stage behind it advances only into an empty slot, so bubbles close up and
// input keeps flowing until the whole pipe is full.
// Reset clears all valid bits and restores the config reset values
// (normal zero, offset zero, band 66, keep front side).
module segment_plane_clipper import scp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  start_x,
	input  logic signed [31:0]  start_y,
	input  logic signed [31:0]  start_z,
	input  logic signed [31:0]  end_x,
	input  logic signed [31:0]  end_y,
	input  logic signed [31:0]  end_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kept,
	output logic [1:0]          start_side,
	output logic [1:0]          end_side,
	output logic signed [31:0]  out_start_x,
	output logic signed [31:0]  out_start_y,
	output logic signed [31:0]  out_start_z,
	output logic signed [31:0]  out_end_x,
	output logic signed [31:0]  out_end_y,
	output logic signed [31:0]  out_end_z
);

	cfg_t cfg_q;
	point_t a_in, b_in, o_start, o_end;
	logic d_valid, d_ready, v_valid, v_ready;
	info_t d_info, v_info;
	logic [DIST_W-1:0] d_num;
	logic [DN_W-1:0] d_den;
	logic [T_W-1:0] v_t;

	assign cfg_ready = 1'b1;

	// config registers, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nx <= '0;
			cfg_q.ny <= '0;
			cfg_q.nz <= '0;
			cfg_q.offset <= '0;
			cfg_q.band <= BAND_RESET;
			cfg_q.keep_back <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NORMAL_X: cfg_q.nx <= cfg_data[NORM_W-1:0];
				REG_NORMAL_Y: cfg_q.ny <= cfg_data[NORM_W-1:0];
				REG_NORMAL_Z: cfg_q.nz <= cfg_data[NORM_W-1:0];
				REG_OFFSET:   cfg_q.offset <= cfg_data[OFFS_W-1:0];
				REG_BAND:     cfg_q.band <= cfg_data[BAND_W-1:0];
				REG_KEEPBACK: cfg_q.keep_back <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign a_in[0] = start_x;
	assign a_in[1] = start_y;
	assign a_in[2] = start_z;
	assign b_in[0] = end_x;
	assign b_in[1] = end_y;
	assign b_in[2] = end_z;

	// signed distances, classes and divider operands
	scp_dist u_dist (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.us_valid(in_valid), .us_ready(in_ready),
		.a_in(a_in), .b_in(b_in),
		.ds_valid(d_valid), .ds_ready(d_ready),
		.info(d_info), .num(d_num), .den(d_den)
	);

	// cut scale t = |Da| / (|Da| + |Db|) in unsigned Q0.30
	scp_div u_div (
		.clk(clk), .arst_n(arst_n),
		.us_valid(d_valid), .us_ready(d_ready),
		.info_in(d_info), .num(d_num), .den(d_den),
		.ds_valid(v_valid), .ds_ready(v_ready),
		.info_out(v_info), .t(v_t)
	);

	// intersection point and result selection; owns the output register
	scp_interp u_interp (
		.clk(clk), .arst_n(arst_n),
		.us_valid(v_valid), .us_ready(v_ready),
		.info_in(v_info), .t(v_t),
		.ds_valid(out_valid), .ds_ready(out_ready),
		.kept(kept), .start_side(start_side), .end_side(end_side),
		.out_start(o_start), .out_end(o_end)
	);

	assign out_start_x = o_start[0];
	assign out_start_y = o_start[1];
	assign out_start_z = o_start[2];
	assign out_end_x = o_end[0];
	assign out_end_y = o_end[1];
	assign out_end_z = o_end[2];

	a_coplanar_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_side == SIDE_COPLANAR && end_side == SIDE_COPLANAR
			|-> kept)
		else $error("fully coplanar segment rejected");

endmodule

// ----- rtl/scp_dist.sv -----
module scp_dist import scp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                us_valid,
	output logic                us_ready,
	input  point_t              a_in,
	input  point_t              b_in,
	output logic                ds_valid,
	input  logic                ds_ready,
	output info_t               info,
	output logic [DIST_W-1:0]   num,
	output logic [DN_W-1:0]     den
);

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0] pa_s1 [3];
	logic signed [PROD_W-1:0] pb_s1 [3];
	point_t a_s1, b_s1, a_s2, b_s2;
	logic signed [DIST_W-1:0] da_s2, db_s2;
	logic signed [DIST_W-1:0] da_c, db_c, band_c;
	logic [1:0] sa_c, sb_c, keep_c, other_c;
	logic whole_c, reject_c;
	logic [DIST_W-1:0] na_c, nb_c;
	info_t info_s3;
	logic [DIST_W-1:0] num_s3;
	logic [DN_W-1:0] den_s3;

	assign en3 = !v_s3 || ds_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign us_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= us_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: one multiplier per axis and endpoint
	always_ff @(posedge clk) begin
		if (en1) begin
			pa_s1[0] <= PROD_W'(cfg.nx) * PROD_W'(a_in[0]);
			pa_s1[1] <= PROD_W'(cfg.ny) * PROD_W'(a_in[1]);
			pa_s1[2] <= PROD_W'(cfg.nz) * PROD_W'(a_in[2]);
			pb_s1[0] <= PROD_W'(cfg.nx) * PROD_W'(b_in[0]);
			pb_s1[1] <= PROD_W'(cfg.ny) * PROD_W'(b_in[1]);
			pb_s1[2] <= PROD_W'(cfg.nz) * PROD_W'(b_in[2]);
			a_s1 <= a_in;
			b_s1 <= b_in;
		end
	end

	// stage 2: sum the products and the offset
	always_ff @(posedge clk) begin
		if (en2) begin
			da_s2 <= DIST_W'(pa_s1[0]) + DIST_W'(pa_s1[1]) + DIST_W'(pa_s1[2])
				+ (DIST_W'(cfg.offset) <<< FRAC_W);
			db_s2 <= DIST_W'(pb_s1[0]) + DIST_W'(pb_s1[1]) + DIST_W'(pb_s1[2])
				+ (DIST_W'(cfg.offset) <<< FRAC_W);
			a_s2 <= a_s1;
			b_s2 <= b_s1;
		end
	end

	// stage 3: classify, pick the case, set up the divider operands
	always_comb begin
		da_c = da_s2;
		db_c = db_s2;
		band_c = DIST_W'({cfg.band, {FRAC_W{1'b0}}});
		if (da_c > band_c) sa_c = SIDE_FRONT;
		else if (da_c < -band_c) sa_c = SIDE_BACK;
		else sa_c = SIDE_COPLANAR;
		if (db_c > band_c) sb_c = SIDE_FRONT;
		else if (db_c < -band_c) sb_c = SIDE_BACK;
		else sb_c = SIDE_COPLANAR;
		keep_c = cfg.keep_back ? SIDE_BACK : SIDE_FRONT;
		other_c = cfg.keep_back ? SIDE_FRONT : SIDE_BACK;
		whole_c = (sa_c != other_c) && (sb_c != other_c);
		reject_c = !whole_c && (sa_c != keep_c) && (sb_c != keep_c);
		na_c = da_c[DIST_W-1] ? DIST_W'(-da_c) : DIST_W'(da_c);
		nb_c = db_c[DIST_W-1] ? DIST_W'(-db_c) : DIST_W'(db_c);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			info_s3.sa <= sa_c;
			info_s3.sb <= sb_c;
			info_s3.kept <= !reject_c;
			info_s3.cut <= !whole_c && !reject_c;
			info_s3.repl_start <= (sa_c != keep_c);
			info_s3.a <= a_s2;
			info_s3.b <= b_s2;
			num_s3 <= na_c;
			den_s3 <= DN_W'(na_c) + DN_W'(nb_c);
		end
	end

	assign ds_valid = v_s3;
	assign info = info_s3;
	assign num = num_s3;
	assign den = den_s3;

	a_cut_strict: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && info_s3.cut |-> info_s3.sa != SIDE_COPLANAR
			&& info_s3.sb != SIDE_COPLANAR && info_s3.sa != info_s3.sb
			&& num_s3 < den_s3)
		else $error("cut with a coplanar end or a degenerate divisor");

endmodule

// ----- rtl/scp_div.sv -----
module scp_div import scp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              us_valid,
	output logic              us_ready,
	input  info_t             info_in,
	input  logic [DIST_W-1:0] num,
	input  logic [DN_W-1:0]   den,
	output logic              ds_valid,
	input  logic              ds_ready,
	output info_t             info_out,
	output logic [T_W-1:0]    t
);

	logic             v_s   [T_W];
	logic             en    [T_W];
	logic [DN_W-1:0]  rem_s [T_W];
	logic [DN_W-1:0]  den_s [T_W];
	logic [T_W-1:0]   q_s   [T_W];
	info_t            inf_s [T_W];

	genvar k;
	generate
		for (k = 0; k < T_W; k++) begin : g_step
			logic             v_src;
			logic [DN_W-1:0]  rem_src;
			logic [DN_W-1:0]  den_src;
			logic [T_W-1:0]   q_src;
			info_t            inf_src;
			logic [DN_W:0]    sh;
			logic             ge;

			if (k == 0) begin : g_first
				assign v_src = us_valid;
				assign rem_src = DN_W'(num);
				assign den_src = den;
				assign q_src = '0;
				assign inf_src = info_in;
			end else begin : g_next
				assign v_src = v_s[k-1];
				assign rem_src = rem_s[k-1];
				assign den_src = den_s[k-1];
				assign q_src = q_s[k-1];
				assign inf_src = inf_s[k-1];
			end

			if (k == T_W - 1) begin : g_last
				assign en[k] = !v_s[k] || ds_ready;
			end else begin : g_mid
				assign en[k] = !v_s[k] || en[k+1];
			end

			// one restoring step: shift, compare, subtract
			assign sh = {rem_src, 1'b0};
			assign ge = sh >= {1'b0, den_src};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[k] <= 1'b0;
				else if (en[k]) v_s[k] <= v_src;
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= ge ? DN_W'(sh - {1'b0, den_src}) : DN_W'(sh);
					den_s[k] <= den_src;
					q_s[k] <= {q_src[T_W-2:0], ge};
					inf_s[k] <= inf_src;
				end
			end
		end
	endgenerate

	assign us_ready = en[0];
	assign ds_valid = v_s[T_W-1];
	assign info_out = inf_s[T_W-1];
	assign t = q_s[T_W-1];

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[T_W-1] && inf_s[T_W-1].cut |-> rem_s[T_W-1] < den_s[T_W-1])
		else $error("divider remainder not below divisor");

endmodule

// ----- rtl/scp_interp.sv -----
module scp_interp import scp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           us_valid,
	output logic           us_ready,
	input  info_t          info_in,
	input  logic [T_W-1:0] t,
	output logic           ds_valid,
	input  logic           ds_ready,
	output logic           kept,
	output logic [1:0]     start_side,
	output logic [1:0]     end_side,
	output point_t         out_start,
	output point_t         out_end
);

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;
	info_t inf_s1, inf_s2;
	logic [T_W-1:0] t_s1;
	logic [DELTA_W-1:0] mag_s1 [3];
	logic neg_s1 [3];
	logic [MUL_W-1:0] prod_s2 [3];
	logic neg_s2 [3];
	logic signed [DELTA_W:0] off_c [3];
	point_t cut_c;
	logic kept_s3;
	logic [1:0] sa_s3, sb_s3;
	point_t st_s3, en_s3;

	assign en3 = !v_s3 || ds_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign us_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= us_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: segment direction as sign and magnitude
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [DELTA_W-1:0] d;
				d = DELTA_W'(info_in.b[i]) - DELTA_W'(info_in.a[i]);
				neg_s1[i] <= d[DELTA_W-1];
				mag_s1[i] <= d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
			end
			inf_s1 <= info_in;
			t_s1 <= t;
		end
	end

	// stage 2: scale each magnitude by t
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= MUL_W'(mag_s1[i]) * MUL_W'(t_s1);
				neg_s2[i] <= neg_s1[i];
			end
			inf_s2 <= inf_s1;
		end
	end

	// stage 3: apply sign, add to start, select the result points
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_c[i] = $signed({1'b0, prod_s2[i][MUL_W-1:T_W]});
			if (neg_s2[i]) off_c[i] = -off_c[i];
			cut_c[i] = COORD_W'((DELTA_W+1)'(inf_s2.a[i]) + off_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			kept_s3 <= inf_s2.kept;
			sa_s3 <= inf_s2.sa;
			sb_s3 <= inf_s2.sb;
			if (!inf_s2.kept) begin
				st_s3 <= '0;
				en_s3 <= '0;
			end else if (!inf_s2.cut) begin
				st_s3 <= inf_s2.a;
				en_s3 <= inf_s2.b;
			end else if (inf_s2.repl_start) begin
				st_s3 <= cut_c;
				en_s3 <= inf_s2.b;
			end else begin
				st_s3 <= inf_s2.a;
				en_s3 <= cut_c;
			end
		end
	end

	assign ds_valid = v_s3;
	assign kept = kept_s3;
	assign start_side = sa_s3;
	assign end_side = sb_s3;
	assign out_start = st_s3;
	assign out_end = en_s3;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !kept_s3 |-> st_s3 == '0 && en_s3 == '0
			&& (sa_s3 != SIDE_COPLANAR || sb_s3 != SIDE_COPLANAR))
		else $error("rejected segment with nonzero points or fully coplanar");

endmodule
